// ----- rtl/tqbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Thick quadratic Bezier stamper package
// Shared types, constants and helper functions for the stamper blocks.
// ----------------------------------------------------------------------------
package tqbs_pkg;

  // Fixed-point format of coordinates
  localparam int unsigned FRAC_BITS     = 4;
  localparam int unsigned DEF_MAX_STEPS = 8191;

  // Configuration register file
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DENSITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEPS    = 2'd2;
  localparam logic [CFG_W-1:0] RST_BEND_RATIO   = 8'd15;
  localparam logic [CFG_W-1:0] RST_STEP_DENSITY = 8'd24;
  localparam logic [CFG_W-1:0] RST_MIN_STEPS    = 8'd4;

  // Datapath widths
  localparam int unsigned ACC_W   = 50;              // curve numerator / MAC
  localparam int unsigned NN_W    = 32;              // n squared
  localparam int unsigned DEN_W   = NN_W + FRAC_BITS;
  localparam int unsigned QB      = 13;              // quotient bits
  localparam int unsigned QUO_W   = QB + 1;          // signed quotient
  localparam int unsigned SQ_W    = 34;              // sum of squares
  localparam int unsigned LEN_W   = 17;              // chord length
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_LFIN,
    ST_STEP,
    ST_WAITX,
    ST_WAITY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] bend_ratio;
    logic [CFG_W-1:0] step_density;
    logic [CFG_W-1:0] min_steps;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               odd_edge;
    logic [15:0]        line_color;
    logic [3:0]         half_size;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = $signed(v[15:0]);
    end
    return r;
  endfunction

  function automatic logic signed [11:0] sat12(input logic signed [14:0] v);
    logic signed [11:0] r;
    if (v > 15'sd2047) begin
      r = 12'sh7ff;
    end else if (v < -15'sd2048) begin
      r = 12'sh800;
    end else begin
      r = $signed(v[11:0]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/tqbs_if.sv -----
// ----------------------------------------------------------------------------
// Stamper channel interfaces
// Request channel (segment loads and stamp requests) and stamp result channel.
// ----------------------------------------------------------------------------
interface tqbs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic               odd_edge;
  logic [15:0]        line_color;
  logic [3:0]         half_size;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, odd_edge,
                  line_color, half_size, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, odd_edge,
                  line_color, half_size, output ready);
endinterface

interface tqbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] rect_x;
  logic signed [11:0] rect_y;
  logic [4:0]         rect_side;
  logic [15:0]        rect_color;
  logic               last;

  modport source (output valid, rect_x, rect_y, rect_side, rect_color, last,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_side, rect_color, last,
                  output ready);
endinterface

// ----- rtl/tqbs_front.sv -----
// ----------------------------------------------------------------------------
// Stamper front end
// Accepts requests, decodes their kind and queues them for the back end.
// ----------------------------------------------------------------------------
module tqbs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tqbs_in_if.sink       in_if,
  output tqbs_pkg::head_t head_o,
  input  logic          pop_i
);
  import tqbs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             cmd_in;
  logic             push, pop;

  always_comb begin
    cmd_in.op         = in_if.kind ? OP_STEP : OP_LOAD;
    cmd_in.start_x    = in_if.start_x;
    cmd_in.start_y    = in_if.start_y;
    cmd_in.end_x      = in_if.end_x;
    cmd_in.end_y      = in_if.end_y;
    cmd_in.odd_edge   = in_if.odd_edge;
    cmd_in.line_color = in_if.line_color;
    cmd_in.half_size  = in_if.half_size;
  end

  assign in_if.ready  = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push         = in_if.valid && in_if.ready;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/tqbs_div.sv -----
// ----------------------------------------------------------------------------
// Stamper rounding divider
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
// ----------------------------------------------------------------------------
module tqbs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tqbs_pkg::ACC_W-1:0] num_i,
  input  logic [tqbs_pkg::DEN_W-1:0]        den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [tqbs_pkg::QUO_W-1:0] quo_o
);
  import tqbs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QB);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] rem_q, dsh_q, mag;
  logic [QB-1:0]    quo_q;

  assign mag    = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Numerator 2|n| + d against divisor 2d gives the rounded magnitude
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (mag << 1) + ACC_W'(den_i);
      dsh_q <= ACC_W'(den_i) << QB;
      neg_q <= num_i[ACC_W-1];
      quo_q <= '0;
      cnt_q <= CNT_W'(QB - 1);
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QB-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QB-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/tqbs_back.sv -----
// ----------------------------------------------------------------------------
// Stamper back end
// Segment setup (length, steps, control point) and per-stamp curve evaluation.
// ----------------------------------------------------------------------------
module tqbs_back #(
  parameter int unsigned MAX_STEPS = tqbs_pkg::DEF_MAX_STEPS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tqbs_pkg::cfg_t  cfg_i,
  input  tqbs_pkg::head_t head_i,
  output logic            pop_o,
  tqbs_out_if.source      out_if
);
  import tqbs_pkg::*;

  localparam int unsigned SW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned PH_W = 5;
  localparam int unsigned MA_W = SQ_W;
  localparam int unsigned MB_W = 17;
  localparam logic [PH_W-1:0] PH_LOAD_LAST = 5'd2;
  localparam logic [PH_W-1:0] PH_SQRT_LAST = 5'(LEN_W - 1);
  localparam logic [PH_W-1:0] PH_LFIN_LAST = 5'd3;
  localparam logic [PH_W-1:0] PH_DIV_X     = 5'd6;
  localparam logic [PH_W-1:0] PH_STEP_LAST = 5'd8;

  state_e             st_q, st_d;
  logic [PH_W-1:0]    ph_q, ph_d;
  logic signed [15:0] pa_x_q, pa_y_q, pb_x_q, pb_y_q, ctrl_x_q, ctrl_y_q;
  logic [SW-1:0]      total_q, index_q;
  logic [15:0]        color_q;
  logic [3:0]         half_q;
  logic               odd_q, active_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [NN_W-1:0]    uu_q, us_q, ss_q;
  logic [SQ_W-1:0]    sq_v_q, sq_res_q, sq_bit_q, sq_t;
  logic signed [QUO_W-1:0] qx_q, qy_q;

  logic               out_valid_q, out_last_q;
  logic signed [11:0] out_x_q, out_y_q;
  logic [4:0]         out_side_q;
  logic [15:0]        out_color_q;

  // control strobes
  logic pop, take_load, out_load, acc_en, acc_clr, div_start;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MA_W+MB_W-1:0] prod;

  logic signed [16:0] dx, dy, mx, my;
  logic signed [17:0] sdx, sdy;
  logic [SW-1:0]      u_cnt;
  logic [NN_W+1:0]    nn_w;
  logic [DEN_W-1:0]   den;
  logic signed [ACC_W-1:0] div_num;
  logic               div_busy, div_done;
  logic signed [QUO_W-1:0] div_quo;
  logic [LEN_W-1:0]   len;
  logic               len_short;
  logic signed [ACC_W-1:0] off_full;
  logic signed [19:0] off20;
  logic [16:0]        raw_steps, steps_lo, steps_mid;
  logic [CFG_W-1:0]   min_eff;
  logic               fin;

  // geometry of the loaded segment
  assign dx  = 17'(pb_x_q) - 17'(pa_x_q);
  assign dy  = 17'(pb_y_q) - 17'(pa_y_q);
  assign mx  = (17'(pa_x_q) + 17'(pb_x_q)) >>> 1;
  assign my  = (17'(pa_y_q) + 17'(pb_y_q)) >>> 1;
  assign sdx = odd_q ? 18'(dx) : -18'(dx);
  assign sdy = odd_q ? -18'(dy) : 18'(dy);
  assign len = sq_res_q[LEN_W-1:0];
  assign len_short = (len < LEN_W'(1 << FRAC_BITS));

  assign u_cnt = total_q - index_q;
  assign nn_w  = (NN_W+2)'(uu_q) + ((NN_W+2)'(us_q) << 1) + (NN_W+2)'(ss_q);
  assign den   = {nn_w[NN_W-1:0], {FRAC_BITS{1'b0}}};
  assign div_num = acc_q;
  assign fin   = (index_q >= total_q);

  // rounded perpendicular offset from the last product
  assign off_full = (acc_q + ACC_W'(128)) >>> 8;
  assign off20    = $signed(off_full[19:0]);

  assign raw_steps = acc_q[FRAC_BITS+4 +: 17];
  assign min_eff   = (cfg_i.min_steps == '0) ? CFG_W'(1) : cfg_i.min_steps;
  assign steps_lo  = (raw_steps < 17'(min_eff)) ? 17'(min_eff) : raw_steps;
  assign steps_mid = (steps_lo > 17'(MAX_STEPS)) ? 17'(MAX_STEPS) : steps_lo;

  // square root step
  assign sq_t = sq_res_q + sq_bit_q;

  assign prod = mul_a * mul_b;

  tqbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // next state, multiplier operands and strobes
  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q + 1'b1;
    pop       = 1'b0;
    take_load = 1'b0;
    out_load  = 1'b0;
    acc_en    = 1'b0;
    acc_clr   = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (st_q)
      ST_IDLE: begin
        ph_d = '0;
        if (head_i.valid) begin
          pop = 1'b1;
          if (head_i.cmd.op == OP_LOAD) begin
            take_load = 1'b1;
            st_d      = ST_LOAD;
          end else if (active_q) begin
            st_d = ST_STEP;
          end
        end
      end
      ST_LOAD: begin
        case (ph_q)
          5'd0: begin
            mul_a = MA_W'(dx); mul_b = dx; acc_en = 1'b1; acc_clr = 1'b1;
          end
          5'd1: begin
            mul_a = MA_W'(dy); mul_b = dy; acc_en = 1'b1;
          end
          default: ;
        endcase
        if (ph_q == PH_LOAD_LAST) begin
          st_d = ST_SQRT;
          ph_d = '0;
        end
      end
      ST_SQRT: begin
        if (ph_q == PH_SQRT_LAST) begin
          st_d = ST_LFIN;
          ph_d = '0;
        end
      end
      ST_LFIN: begin
        acc_en  = 1'b1;
        acc_clr = 1'b1;
        case (ph_q)
          5'd0: begin
            mul_a = $signed(MA_W'(len)); mul_b = $signed(MB_W'(cfg_i.step_density));
          end
          5'd1: begin
            mul_a = MA_W'(sdy); mul_b = $signed(MB_W'(cfg_i.bend_ratio));
          end
          5'd2: begin
            mul_a = MA_W'(sdx); mul_b = $signed(MB_W'(cfg_i.bend_ratio));
          end
          default: acc_en = 1'b0;
        endcase
        if (ph_q == PH_LFIN_LAST) begin
          st_d = ST_IDLE;
        end
      end
      ST_STEP: begin
        case (ph_q)
          5'd0: begin
            mul_a = $signed(MA_W'(u_cnt)); mul_b = $signed(MB_W'(u_cnt));
          end
          5'd1: begin
            mul_a = $signed(MA_W'(u_cnt)); mul_b = $signed(MB_W'(index_q));
          end
          5'd2: begin
            mul_a = $signed(MA_W'(index_q)); mul_b = $signed(MB_W'(index_q));
          end
          5'd3, 5'd6: begin
            mul_a   = $signed(MA_W'(uu_q));
            mul_b   = (ph_q == 5'd3) ? MB_W'(pa_x_q) : MB_W'(pa_y_q);
            acc_en  = 1'b1;
            acc_clr = 1'b1;
          end
          5'd4, 5'd7: begin
            mul_a  = $signed({1'b0, us_q, 1'b0});
            mul_b  = (ph_q == 5'd4) ? MB_W'(ctrl_x_q) : MB_W'(ctrl_y_q);
            acc_en = 1'b1;
          end
          5'd5, 5'd8: begin
            mul_a  = $signed(MA_W'(ss_q));
            mul_b  = (ph_q == 5'd5) ? MB_W'(pb_x_q) : MB_W'(pb_y_q);
            acc_en = 1'b1;
          end
          default: ;
        endcase
        // x numerator is complete: divide it while the y numerator builds
        if (ph_q == PH_DIV_X) begin
          div_start = 1'b1;
        end
        if (ph_q == PH_STEP_LAST) begin
          st_d = ST_WAITX;
        end
      end
      ST_WAITX: begin
        if (div_done) begin
          div_start = 1'b1;
          st_d      = ST_WAITY;
        end
      end
      ST_WAITY: begin
        if (div_done) begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ph_q        <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      if (take_load) begin
        active_q <= 1'b1;
      end else if (out_load && fin) begin
        active_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_load) begin
      pa_x_q  <= head_i.cmd.start_x;
      pa_y_q  <= head_i.cmd.start_y;
      pb_x_q  <= head_i.cmd.end_x;
      pb_y_q  <= head_i.cmd.end_y;
      odd_q   <= head_i.cmd.odd_edge;
      color_q <= head_i.cmd.line_color;
      half_q  <= head_i.cmd.half_size;
      index_q <= '0;
    end else if (out_load && !fin) begin
      index_q <= index_q + 1'b1;
    end

    if (acc_en) begin
      acc_q <= ACC_W'(prod) + (acc_clr ? '0 : acc_q);
    end

    if (st_q == ST_STEP) begin
      case (ph_q)
        5'd0:    uu_q <= NN_W'(prod);
        5'd1:    us_q <= NN_W'(prod);
        5'd2:    ss_q <= NN_W'(prod);
        default: ;
      endcase
    end

    // bit-pair square root of the sum of squares
    if (st_q == ST_LOAD && ph_q == PH_LOAD_LAST) begin
      sq_v_q   <= SQ_W'(acc_q);
      sq_res_q <= '0;
      sq_bit_q <= SQ_W'(1) << (2 * (LEN_W - 1));
    end else if (st_q == ST_SQRT) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q   <= sq_v_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end

    if (st_q == ST_LFIN) begin
      case (ph_q)
        5'd1:    total_q  <= SW'(steps_mid);
        5'd2:    ctrl_x_q <= sat16(len_short ? 20'(mx) : 20'(mx) + off20);
        5'd3:    ctrl_y_q <= sat16(len_short ? 20'(my) : 20'(my) + off20);
        default: ;
      endcase
    end

    if (st_q == ST_WAITX && div_done) begin
      qx_q <= div_quo;
    end
    if (st_q == ST_WAITY && div_done) begin
      qy_q <= div_quo;
    end

    if (out_load) begin
      out_x_q     <= sat12(15'(qx_q) - 15'(half_q));
      out_y_q     <= sat12(15'(qy_q) - 15'(half_q));
      out_side_q  <= {half_q, 1'b0};
      out_color_q <= color_q;
      out_last_q  <= fin;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.rect_x     = out_x_q;
  assign out_if.rect_y     = out_y_q;
  assign out_if.rect_side  = out_side_q;
  assign out_if.rect_color = out_color_q;
  assign out_if.last       = out_last_q;

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && st_q == ST_IDLE) |-> (index_q <= total_q))
    else $error("stamp index past step total");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && st_q == ST_IDLE) |-> (total_q != '0))
    else $error("active segment with zero steps");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/thick_quadratic_bezier_stamper_unit.sv -----
// ----------------------------------------------------------------------------
// Thick quadratic Bezier stamper
// Turns a segment into a run of square stamps along a bent quadratic curve.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries requests. kind 0 loads a segment (endpoints, parity, color,
//   half size); kind 1 asks for the next stamp of the loaded segment. A load
//   yields no result; each stamp request yields one rectangle on out_if until
//   the stamp flagged last has gone out, after which requests are dropped.
//   A segment of n steps gives n+1 stamps.
//   Configuration (bend ratio, step density, minimum steps) is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while the block
//   is idle, as the block itself does not enforce it. Unknown indexes are ignored.
// Timing:
//   A two-entry queue sits between the request side and the datapath, so
//   requests are taken while earlier ones are still being worked on.
//   Setting up a segment takes the request, forms the squared chord, runs the
//   bit-pair square root and then sets the step count and control point. A
//   stamp goes from the queue head to the output register by taking the
//   request, forming nine products on the shared multiplier and making two
//   passes of the rounding divider, one per axis, the x pass overlapping the
//   last y products.
//   The result sits in an output register; a stalled receiver holds it there
//   and the datapath waits for the slot, while the queue keeps filling.
// Reset:
//   Clears the queue, drops any loaded segment and restores the register
//   defaults (bend 15, density 24, minimum steps 4).
// ----------------------------------------------------------------------------
module thick_quadratic_bezier_stamper_unit #(
  parameter int unsigned MAX_STEPS = tqbs_pkg::DEF_MAX_STEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tqbs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tqbs_pkg::CFG_W-1:0]         cfg_data_i,
  tqbs_in_if.sink                            in_if,
  tqbs_out_if.source                         out_if
);
  import tqbs_pkg::*;

  cfg_t  cfg_q;
  head_t head;
  logic  pop;

  // Configuration registers: write one, hold the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bend_ratio   <= RST_BEND_RATIO;
      cfg_q.step_density <= RST_STEP_DENSITY;
      cfg_q.min_steps    <= RST_MIN_STEPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEND_RATIO:   cfg_q.bend_ratio   <= cfg_data_i;
        CFG_STEP_DENSITY: cfg_q.step_density <= cfg_data_i;
        CFG_MIN_STEPS:    cfg_q.min_steps    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: decode and queue requests
  tqbs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back: segment setup and stamp evaluation, drives the result register
  tqbs_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_if (out_if)
  );

endmodule

// ----- bench/tb_thick_quadratic_bezier_stamper_unit.sv -----
// ----------------------------------------------------------------------------
// Bezier stamper testbench
// Drives segment loads and stamp requests with random gaps, predicts every
// stamp rectangle from a bit-exact curve model and checks results in order.
// ----------------------------------------------------------------------------
import tqbs_pkg::*;

typedef struct packed {
  logic signed [11:0] rect_x;
  logic signed [11:0] rect_y;
  logic [4:0]         rect_side;
  logic [15:0]        rect_color;
  logic               last;
} stamp_t;

class stamp_scoreboard;
  // configuration copy
  int unsigned bend, density, min_n;
  // curve state
  longint ax, ay, bx, by, cx, cy;
  longint unsigned n_total, s_idx;
  logic [15:0] color;
  int unsigned half;
  bit seg_active;
  stamp_t pending[$];
  int unsigned errors;

  function new();
    bend = 15; density = 24; min_n = 4;
    seg_active = 0; errors = 0;
    ax = 0; ay = 0; bx = 0; by = 0; cx = 0; cy = 0;
    n_total = 0; s_idx = 0; color = 0; half = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    case (idx)
      CFG_BEND_RATIO:   bend = v;
      CFG_STEP_DENSITY: density = v;
      CFG_MIN_STEPS:    min_n = v;
      default: ;
    endcase
  endfunction

  static function longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  static function longint unsigned chord_len(longint unsigned v);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  static function longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  static function longint bezier_px(longint a, longint c, longint b, longint n, longint s);
    longint u, num, den, mag, q;
    u = n - s;
    num = u * u * a + 2 * u * s * c + s * s * b;
    den = n * n * 16;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  // note an accepted request; a stamp request may queue one expected rect
  function void note_request(cmd_t c);
    longint dx, dy, mx, my, k, ppx, ppy;
    longint unsigned len, steps, lo;
    stamp_t r;
    if (c.op == OP_LOAD) begin
      dx = longint'(c.end_x) - longint'(c.start_x);
      dy = longint'(c.end_y) - longint'(c.start_y);
      mx = fdiv(longint'(c.start_x) + longint'(c.end_x), 2);
      my = fdiv(longint'(c.start_y) + longint'(c.end_y), 2);
      len = chord_len(dx * dx + dy * dy);
      if (len >= 16) begin
        k = c.odd_edge ? 1 : -1;
        mx += fdiv(-k * dy * bend + 128, 256);
        my += fdiv(k * dx * bend + 128, 256);
      end
      steps = (len * density) >> 8;
      lo = min_n ? min_n : 1;
      if (steps < lo) steps = lo;
      if (steps > DEF_MAX_STEPS) steps = DEF_MAX_STEPS;
      ax = c.start_x; ay = c.start_y; bx = c.end_x; by = c.end_y;
      cx = sat(mx, -32768, 32767); cy = sat(my, -32768, 32767);
      n_total = steps; s_idx = 0;
      color = c.line_color; half = c.half_size;
      seg_active = 1;
    end else if (seg_active) begin
      ppx = bezier_px(ax, cx, bx, n_total, s_idx);
      ppy = bezier_px(ay, cy, by, n_total, s_idx);
      r.rect_x = sat(ppx - half, -2048, 2047);
      r.rect_y = sat(ppy - half, -2048, 2047);
      r.rect_side = 2 * half;
      r.rect_color = color;
      r.last = (s_idx >= n_total);
      pending.push_back(r);
      if (r.last) seg_active = 0;
      else s_idx++;
    end
  endfunction

  function void check_stamp(stamp_t got);
    stamp_t exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected stamp %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("stamp mismatch: expected %p, got %p", exp_r, got);
    end
  endfunction
endclass

module tb_thick_quadratic_bezier_stamper_unit;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int unsigned cycles = 0;
  bit stim_done = 0;
  stamp_scoreboard board = new();

  tqbs_in_if  in_if();
  tqbs_out_if out_if();

  thick_quadratic_bezier_stamper_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0; in_if.kind = OP_LOAD;
    in_if.start_x = '0; in_if.start_y = '0; in_if.end_x = '0; in_if.end_y = '0;
    in_if.odd_edge = 1'b0; in_if.line_color = '0; in_if.half_size = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: random stalls, check each rectangle at the accepting edge.
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (w != 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      board.check_stamp('{out_if.rect_x, out_if.rect_y, out_if.rect_side,
                          out_if.rect_color, out_if.last});
    end
  end

  // Hold the request for one accepting edge; gap drawn per request.
  task automatic send_request(cmd_t c, bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1; in_if.kind <= c.op;
    in_if.start_x <= c.start_x; in_if.start_y <= c.start_y;
    in_if.end_x <= c.end_x; in_if.end_y <= c.end_y;
    in_if.odd_edge <= c.odd_edge; in_if.line_color <= c.line_color;
    in_if.half_size <= c.half_size;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_request(c);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every stamp is out, then let the tail drain.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, v);
  endtask

  function automatic cmd_t rand_load(int unsigned span);
    cmd_t c;
    c.op = OP_LOAD;
    c.start_x = $signed(16'($urandom)) >>> span;
    c.start_y = $signed(16'($urandom)) >>> span;
    c.end_x = c.start_x + ($signed(16'($urandom)) >>> (span + 2));
    c.end_y = c.start_y + ($signed(16'($urandom)) >>> (span + 2));
    c.odd_edge = 1'($urandom); c.line_color = 16'($urandom);
    c.half_size = 4'($urandom);
    return c;
  endfunction

  function automatic cmd_t step_req();
    cmd_t c;
    c = '0;
    c.op = OP_STEP;
    c.start_x = 16'($urandom); c.line_color = 16'($urandom); // ignored payload noise
    return c;
  endfunction

  // Load one segment and request all its stamps (plus an optional overrun).
  task automatic run_segment(cmd_t c, int unsigned extra);
    send_request(c);
    while (board.seg_active) send_request(step_req(), $urandom_range(0, 2) == 0);
    repeat (extra) send_request(step_req());
  endtask

  initial begin
    cmd_t c;
    int unsigned sent;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: step with no segment, then extremes at reset bend and density.
    send_request(step_req());
    drain();
    write_reg(CFG_MIN_STEPS, 8'd2);
    c = '{OP_LOAD, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, 16'hffff, 4'hf};
    send_request(c);                               // long chord, saturating
    send_request(step_req());
    send_request(step_req());
    c = '{OP_LOAD, 16'sh0005, 16'sh0003, 16'sh0008, 16'sh0001, 1'b0, 16'h0000, 4'h0};
    run_segment(c, 2);                             // short chord, then overrun
    c = '{OP_LOAD, 16'sh7ff0, 16'sh7ff0, 16'sh8000, 16'sh8000, 1'b0, 16'h5a5a, 4'h7};
    send_request(c);                               // step count at its ceiling
    repeat (3) send_request(step_req());
    drain();

    // Bend at extremes, density low, minimum of zero.
    write_reg(CFG_BEND_RATIO, 8'd255);
    write_reg(CFG_STEP_DENSITY, 8'd1);
    write_reg(CFG_MIN_STEPS, 8'd0);
    c = '{OP_LOAD, -16'sd800, 16'sd300, 16'sd900, -16'sd700, 1'b1, 16'h1234, 4'h3};
    run_segment(c, 1);
    c = '{OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'hf00f, 4'h8};
    run_segment(c, 0);                             // zero chord, one step
    drain();

    // Random phases over several register settings.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BEND_RATIO, ph == 0 ? 8'd0 : 8'($urandom));
      write_reg(CFG_STEP_DENSITY, ph == 1 ? 8'd255 : 8'($urandom_range(1, 40)));
      write_reg(CFG_MIN_STEPS, ph == 2 ? 8'd255 : 8'($urandom_range(1, 12)));
      while (sent < (ph + 1) * 75) begin
        c = rand_load($urandom_range(4, 7));
        if ($urandom_range(0, 7) == 0) begin
          // broken sequence: abandon the segment part way
          send_request(c);
          repeat ($urandom_range(0, 4)) send_request(step_req());
          sent += 3;
        end else begin
          run_segment(c, $urandom_range(0, 4) == 0);
          sent += board.n_total + 2;
        end
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
